/* rtl/rtma_pkg.sv */
// rtma_pkg: shared types and constants for the right triangle magnitude and angle block
// word structs for both channels, stage payload struct, cordic arctangent table
// no dependencies
package rtma_pkg;

   localparam int LEG_BITS    = 16;
   localparam int GUARD_BITS  = 20;
   localparam int HYP_BITS    = LEG_BITS + 1;
   localparam int ANGLE_BITS  = 15;
   localparam int XY_BITS     = LEG_BITS + GUARD_BITS + 3;
   localparam int Z_BITS      = 25;
   localparam int REM_BITS    = 2 * LEG_BITS + 1;
   localparam int TRIAL_BITS  = REM_BITS + 2;
   localparam int TABLE_LEN   = 32;

   localparam logic [ANGLE_BITS-1:0] DEG90_Q8 = 15'd23040;
   localparam logic [Z_BITS-1:0] ROUND_HALF = 25'd128;

   // atan(2^-i) in degrees, q.16
   localparam logic signed [Z_BITS-1:0] ATAN_TABLE [TABLE_LEN] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
      25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
      25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
      25'sd917,     25'sd458,     25'sd229,    25'sd115,
      25'sd57,      25'sd29,      25'sd14,     25'sd7,
      25'sd4,       25'sd2,       25'sd1,      25'sd0,
      25'sd0,       25'sd0,       25'sd0,      25'sd0,
      25'sd0,       25'sd0,       25'sd0,      25'sd0
   };

   typedef struct packed {
      logic [LEG_BITS-1:0] leg_a;
      logic [LEG_BITS-1:0] leg_b;
   } req_word_type;

   typedef struct packed {
      logic [HYP_BITS-1:0]   hyp_len;
      logic [ANGLE_BITS-1:0] angle_opp_b;
      logic [ANGLE_BITS-1:0] angle_opp_a;
      logic                  degenerate;
   } rsp_word_type;

   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic signed [Z_BITS-1:0]  z;
      logic [REM_BITS-1:0]       rem;
      logic [HYP_BITS-1:0]       root;
      logic                      a_zero;
      logic                      b_zero;
   } stage_type;

endpackage

/* rtl/rtma_stage.sv */
// rtma_stage: one pipeline stage, one cordic vectoring step and one square root digit
// either step is skipped when the stage index lies past its count
// depends on rtma_pkg
module rtma_stage
   import rtma_pkg::*;
#(
   parameter int STEP       = 0,
   parameter int ITERATIONS = 18
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  stage_type in_data,
   output logic      out_valid,
   output stage_type out_data
);

   localparam bit DO_ROT  = (STEP < ITERATIONS);
   localparam bit DO_ROOT = (STEP < HYP_BITS);
   localparam int K       = DO_ROOT ? (HYP_BITS - 1 - STEP) : 0;
   localparam int TAB_IDX = (STEP < TABLE_LEN) ? STEP : 0;

   logic                      valid_ff;
   stage_type                 data_ff;
   stage_type                 data_in;
   logic signed [XY_BITS-1:0] x_cur;
   logic signed [XY_BITS-1:0] y_cur;
   logic signed [XY_BITS-1:0] x_shr;
   logic signed [XY_BITS-1:0] y_shr;
   logic [TRIAL_BITS-1:0]     trial;
   logic [TRIAL_BITS-1:0]     rem_wide;

   always_comb begin
      x_cur    = in_data.x;
      y_cur    = in_data.y;
      x_shr    = x_cur >>> STEP;
      y_shr    = y_cur >>> STEP;
      trial    = (TRIAL_BITS'(in_data.root) << (K + 1))
               + (TRIAL_BITS'(1) << (2 * K));
      rem_wide = TRIAL_BITS'(in_data.rem);
      data_in  = in_data;
      if (DO_ROT) begin
         if (y_cur > 0) begin
            data_in.x = x_cur + y_shr;
            data_in.y = y_cur - x_shr;
            data_in.z = in_data.z + ATAN_TABLE[TAB_IDX];
         end else begin
            data_in.x = x_cur - y_shr;
            data_in.y = y_cur + x_shr;
            data_in.z = in_data.z - ATAN_TABLE[TAB_IDX];
         end
      end
      if (DO_ROOT && (rem_wide >= trial)) begin
         data_in.rem  = in_data.rem - trial[REM_BITS-1:0];
         data_in.root = in_data.root | (HYP_BITS'(1) << K);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/right_triangle_magnitude_angle.sv */
// right_triangle_magnitude_angle: hypotenuse and both acute angles of a right triangle
// squares legs, runs a pipelined cordic and a bit-per-stage square root side by side
// depends on rtma_pkg and rtma_stage
//
// usage
//   input: raise start with req_word (leg_a, leg_b, unsigned q8.8); a word is taken
//   at every rising edge with start high and busy low. busy stays low, so a new
//   word can enter on every cycle.
//   output: rsp_strobe is high for one cycle with rsp_word (hyp_len q9.8,
//   angle_opp_b and angle_opp_a in degrees q7.8, degenerate flag).
//   path: an accepted word passes two front stages that square and sum the legs,
//   then the stage chain where each stage does at most one cordic step and one
//   root digit, then one back stage that rounds and clamps.
//   throughput: one word per cycle.
//   reset: clears all stage valid bits, words in flight are dropped.
//   the receiver has no way to stall, results are shown once in arrival order.
module right_triangle_magnitude_angle
   import rtma_pkg::*;
#(
   parameter int ITERATIONS = 18
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int NSTAGE  = (ITERATIONS > HYP_BITS) ? ITERATIONS : HYP_BITS;
   localparam int LATENCY = NSTAGE + 3;

   logic                      req_accept;

   logic                      f0_valid_ff;
   logic [LEG_BITS-1:0]       f0_a_ff;
   logic [LEG_BITS-1:0]       f0_b_ff;
   logic [2*LEG_BITS-1:0]     f0_sq_a_ff;
   logic [2*LEG_BITS-1:0]     f0_sq_b_ff;
   logic [2*LEG_BITS-1:0]     f0_sq_a_in;
   logic [2*LEG_BITS-1:0]     f0_sq_b_in;

   logic                      f1_valid_ff;
   stage_type                 f1_data_ff;
   stage_type                 f1_data_in;

   logic                      pipe_valid [NSTAGE+1];
   stage_type                 pipe_data  [NSTAGE+1];

   logic                      out_valid_ff;
   rsp_word_type              out_word_ff;
   rsp_word_type              out_word_in;

   stage_type                 last;
   logic [Z_BITS-1:0]         z_pos;
   logic [Z_BITS:0]           z_sum;
   logic [Z_BITS-8:0]         ang_full;
   logic [ANGLE_BITS-1:0]     ang_clamp;
   logic [ANGLE_BITS-1:0]     ang_final;

   assign busy       = 1'b0;
   assign req_accept = start & ~busy;

   // front: leg squares
   assign f0_sq_a_in = (2*LEG_BITS)'(req_word.leg_a) * (2*LEG_BITS)'(req_word.leg_a);
   assign f0_sq_b_in = (2*LEG_BITS)'(req_word.leg_b) * (2*LEG_BITS)'(req_word.leg_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff <= req_accept;
         f1_valid_ff <= f0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f0_a_ff    <= req_word.leg_a;
      f0_b_ff    <= req_word.leg_b;
      f0_sq_a_ff <= f0_sq_a_in;
      f0_sq_b_ff <= f0_sq_b_in;
      f1_data_ff <= f1_data_in;
   end

   // sum of squares and cordic start vector
   always_comb begin
      f1_data_in.x      = XY_BITS'(f0_a_ff) << GUARD_BITS;
      f1_data_in.y      = XY_BITS'(f0_b_ff) << GUARD_BITS;
      f1_data_in.z      = '0;
      f1_data_in.rem    = REM_BITS'(f0_sq_a_ff) + REM_BITS'(f0_sq_b_ff);
      f1_data_in.root   = '0;
      f1_data_in.a_zero = (f0_a_ff == '0);
      f1_data_in.b_zero = (f0_b_ff == '0);
   end

   assign pipe_valid[0] = f1_valid_ff;
   assign pipe_data[0]  = f1_data_ff;

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      rtma_stage #(
         .STEP       (s),
         .ITERATIONS (ITERATIONS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[s]),
         .in_data   (pipe_data[s]),
         .out_valid (pipe_valid[s+1]),
         .out_data  (pipe_data[s+1])
      );
   end

   // back: rounding, clamping, special cases
   always_comb begin
      last      = pipe_data[NSTAGE];
      z_pos     = (last.z < 0) ? '0 : last.z;
      z_sum     = {1'b0, z_pos} + {1'b0, ROUND_HALF};
      ang_full  = z_sum[Z_BITS:8];
      ang_clamp = (ang_full > (Z_BITS-7)'(DEG90_Q8)) ? DEG90_Q8
                                                     : ang_full[ANGLE_BITS-1:0];
      if (last.b_zero) begin
         ang_final = '0;
      end else if (last.a_zero) begin
         ang_final = DEG90_Q8;
      end else begin
         ang_final = ang_clamp;
      end
      out_word_in.hyp_len     = last.root
                              + HYP_BITS'(last.rem > REM_BITS'(last.root));
      out_word_in.angle_opp_b = ang_final;
      out_word_in.angle_opp_a = DEG90_Q8 - ang_final;
      out_word_in.degenerate  = last.a_zero & last.b_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= pipe_valid[NSTAGE];
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_word   = out_word_ff;

`ifndef NO_ASSERTIONS
   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, LATENCY))
      else $error("result word without a matching accepted word");

   a_degenerate_legs: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.degenerate ==
         ($past(req_word.leg_a, LATENCY) == '0 && $past(req_word.leg_b, LATENCY) == '0)))
      else $error("degenerate flag does not match legs");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.angle_opp_b <= DEG90_Q8 && rsp_word.angle_opp_a <= DEG90_Q8))
      else $error("angle out of range");
`endif

endmodule

/* dv/testbench.sv */
// testbench for right_triangle_magnitude_angle: legs in, hypotenuse and both angles out
// predicts every word with its own exact root and cordic angle and checks each strobe
// depends on rtma_pkg and the rtl of right_triangle_magnitude_angle
module testbench;
   import rtma_pkg::*;

   localparam int CORDIC_STEPS = 18;
   localparam logic [14:0] RIGHT_ANGLE_Q8 = 15'd23040;
   localparam int DRAIN_CYCLES = 40;
   localparam int DRAIN_LIMIT = 400;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_word_type req_word;
   logic rsp_strobe;
   rsp_word_type rsp_word;

   rsp_word_type pending_polar [$];
   bit gaps_on;
   int error_count;
   int legs_sent;
   int results_checked;
   int degenerate_seen;

   right_triangle_magnitude_angle #(.ITERATIONS(CORDIC_STEPS)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // arctangent of 2^-k in degrees, q.16
   function automatic longint arctan_deg_q16(input int k);
      case (k)
         0: return 2949120;
         1: return 1740967;
         2: return 919879;
         3: return 466945;
         4: return 234379;
         5: return 117304;
         6: return 58666;
         7: return 29335;
         8: return 14668;
         9: return 7334;
         10: return 3667;
         11: return 1833;
         12: return 917;
         13: return 458;
         14: return 229;
         15: return 115;
         16: return 57;
         17: return 29;
         18: return 14;
         19: return 7;
         20: return 4;
         21: return 2;
         22: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic logic [16:0] hypotenuse_q8(input logic [15:0] a, input logic [15:0] b);
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned sum_sq;
      longint unsigned root;
      longint unsigned cand;
      ua = a;
      ub = b;
      sum_sq = ua * ua + ub * ub;
      root = 0;
      // largest root with root*(root-1) below the sum rounds to nearest
      for (int k = 16; k >= 0; k--) begin
         cand = root | (64'd1 << k);
         if (cand * (cand - 1) < sum_sq) begin
            root = cand;
         end
      end
      return root[16:0];
   endfunction

   function automatic logic [14:0] leg_angle_q8(input logic [15:0] a, input logic [15:0] b);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint q;
      if (b == 0) return 15'd0;
      if (a == 0) return RIGHT_ANGLE_Q8;
      x = a;
      y = b;
      x = x << 20;
      y = y << 20;
      z = 0;
      for (int k = 0; k < CORDIC_STEPS && k < 32; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_deg_q16(k);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_deg_q16(k);
         end
      end
      if (z < 0) z = 0;
      q = (z + 128) >>> 8;
      if (q > RIGHT_ANGLE_Q8) q = RIGHT_ANGLE_Q8;
      return q[14:0];
   endfunction

   function automatic rsp_word_type polar_of_legs(input logic [15:0] a, input logic [15:0] b);
      rsp_word_type p;
      logic [14:0] ang;
      if (a == 0 && b == 0) begin
         p.hyp_len = '0;
         p.angle_opp_b = '0;
         p.angle_opp_a = RIGHT_ANGLE_Q8;
         p.degenerate = 1'b1;
      end else begin
         ang = leg_angle_q8(a, b);
         p.hyp_len = hypotenuse_q8(a, b);
         p.angle_opp_b = ang;
         p.angle_opp_a = RIGHT_ANGLE_Q8 - ang;
         p.degenerate = 1'b0;
      end
      return p;
   endfunction

   task automatic send_legs(input logic [15:0] a, input logic [15:0] b);
      req_word_type w;
      w.leg_a = a;
      w.leg_b = b;
      while (gaps_on && $urandom_range(99) < 20) begin
         start <= 1'b0;
         req_word <= req_word_type'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pending_polar.push_back(polar_of_legs(a, b));
      legs_sent++;
   endtask

   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_polar.size() == 0) begin
            $error("result word with nothing expected: %p", rsp_word);
            error_count++;
         end else begin
            want = pending_polar.pop_front();
            results_checked++;
            if (rsp_word.degenerate) degenerate_seen++;
            if (rsp_word.hyp_len !== want.hyp_len) begin
               $error("hyp_len expected %0d actual %0d", want.hyp_len, rsp_word.hyp_len);
               error_count++;
            end
            if (rsp_word.angle_opp_b !== want.angle_opp_b) begin
               $error("angle_opp_b expected %0d actual %0d",
                      want.angle_opp_b, rsp_word.angle_opp_b);
               error_count++;
            end
            if (rsp_word.angle_opp_a !== want.angle_opp_a) begin
               $error("angle_opp_a expected %0d actual %0d",
                      want.angle_opp_a, rsp_word.angle_opp_a);
               error_count++;
            end
            if (rsp_word.degenerate !== want.degenerate) begin
               $error("degenerate expected %0b actual %0b",
                      want.degenerate, rsp_word.degenerate);
               error_count++;
            end
         end
      end
   end

   task automatic test_corner_legs();
      gaps_on = 1'b1;
      send_legs(16'h0000, 16'h0000);
      send_legs(16'h0000, 16'h0001);
      send_legs(16'h0000, 16'hFFFF);
      send_legs(16'h0001, 16'h0000);
      send_legs(16'hFFFF, 16'h0000);
      send_legs(16'hFFFF, 16'hFFFF);
      send_legs(16'h0001, 16'h0001);
      send_legs(16'h0001, 16'hFFFF);
      send_legs(16'hFFFF, 16'h0001);
      send_legs(16'h0300, 16'h0400);
      send_legs(16'h0100, 16'h0100);
      send_legs(16'h8000, 16'h8000);
      send_legs(16'h5555, 16'hAAAA);
      send_legs(16'hAAAA, 16'h5555);
      send_legs(16'h0002, 16'h0001);
      send_legs(16'h0000, 16'h0000);
      send_legs(16'h7FFF, 16'h8000);
      send_legs(16'h0000, 16'h8000);
   endtask

   task automatic random_pair(output logic [15:0] a, output logic [15:0] b);
      a = $urandom;
      b = $urandom;
      case ($urandom_range(9))
         0: if ($urandom_range(1)) a = '0; else b = '0;
         1: begin
            a = $urandom_range(255);
            b = $urandom_range(255);
         end
         2: b = $urandom_range(15);
         3: a = $urandom_range(15);
         4: b = a;
         5: if ($urandom_range(7) == 0) begin
            a = '0;
            b = '0;
         end
         default: ;
      endcase
   endtask

   task automatic test_random_legs(input int count);
      logic [15:0] a;
      logic [15:0] b;
      gaps_on = 1'b1;
      repeat (count) begin
         random_pair(a, b);
         send_legs(a, b);
      end
   endtask

   task automatic test_back_to_back(input int count);
      logic [15:0] a;
      logic [15:0] b;
      gaps_on = 1'b0;
      repeat (count) begin
         random_pair(a, b);
         send_legs(a, b);
      end
   endtask

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int waited;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      gaps_on = 1'b0;
      error_count = 0;
      legs_sent = 0;
      results_checked = 0;
      degenerate_seen = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_legs();
      test_random_legs(900);
      test_back_to_back(300);
      test_random_legs(130);

      start <= 1'b0;
      waited = 0;
      while (pending_polar.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_polar.size() != 0) begin
         $error("%0d result words never arrived", pending_polar.size());
         error_count++;
      end

      $display("sent %0d leg pairs, checked %0d results, %0d of them degenerate",
               legs_sent, results_checked, degenerate_seen);
      $display("covered zero legs, full-scale legs, random pairs with gaps and back to back");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
